// ----- src/dgcba_pkg.sv -----
package dgcba_pkg;

   localparam int FrameWidth   = 1024;
   localparam int FrameHeight  = 512;
   localparam int MaxLumaCount = 1023;

   localparam int ChromaW     = (FrameWidth + 1) / 2;
   localparam int ChromaH     = (FrameHeight + 1) / 2;
   localparam int LumaCells   = FrameWidth * FrameHeight;
   localparam int ChromaCells = ChromaW * ChromaH;
   localparam int MaxChromaCount = 4 * MaxLumaCount + 3;

   localparam int LumaAw   = $clog2(LumaCells);
   localparam int ChromaAw = $clog2(ChromaCells);
   localparam int LcntW    = $clog2(MaxLumaCount + 1);
   localparam int CcntW    = $clog2(MaxChromaCount + 1);
   localparam int LsumW    = LcntW + 8;
   localparam int CsumW    = CcntW + 8;
   localparam int LumaMemW   = LsumW + LcntW;
   localparam int ChromaMemW = 2 * CsumW + CcntW;
   localparam int RowW = 9;
   localparam int ColW = 10;
   localparam int QDepth = 4;
   localparam int QAw = 2;
   localparam int DivW = CsumW;

   localparam logic [7:0] DepthMax = 8'd255;
   localparam logic [7:0] TolReset = 8'd8;

   typedef enum logic {
      KIND_SAMPLE  = 1'b0,
      KIND_READOUT = 1'b1
   } kind_type;

   // Queue entry: classified item from front to back
   typedef struct packed {
      kind_type            kind;
      logic                in_frame;
      logic                in_band;
      logic [LumaAw-1:0]   luma_addr;
      logic [ChromaAw-1:0] chroma_addr;
      logic [7:0]          luma;
      logic [7:0]          cb;
      logic [7:0]          cr;
   } op_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] luma_mean;
      logic       luma_valid;
      logic [7:0] cb_mean;
      logic [7:0] cr_mean;
      logic       chroma_valid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ----- src/dgcba_ram.sv -----
module dgcba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- src/dgcba_front.sv -----
module dgcba_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_kind,
   input  logic [58:0]            in_data,
   output logic                   q_valid,
   input  logic                   q_ready,
   output dgcba_pkg::op_type      q_op
);
   import dgcba_pkg::*;

   logic [7:0] tol_ff, tol_in;
   op_type     mem_ff [QDepth];
   logic [QAw-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QAw:0]   cnt_ff, cnt_in;
   op_type     op;
   logic [RowW-1:0] row;
   logic [ColW-1:0] col;
   logic [7:0] dnow, dbg;
   logic [8:0] hi;
   logic [7:0] lo, hi_c;
   logic push, pop;

   assign csr_ready = 1'b1;
   assign tol_in = (csr_valid) ? csr_data : tol_ff;

   assign row  = in_data[RowW-1:0];
   assign col  = in_data[RowW+ColW-1:RowW];
   assign dnow = in_data[26:19];
   assign dbg  = in_data[34:27];

   always_comb begin
      hi   = {1'b0, dbg} + {1'b0, tol_ff};
      hi_c = hi[8] ? DepthMax : hi[7:0];
      lo   = (dbg >= tol_ff) ? dbg - tol_ff : 8'd0;
      op.kind     = kind_type'(in_kind);
      op.in_frame = (32'(row) < FrameHeight) && (32'(col) < FrameWidth);
      op.in_band  = (dnow >= lo) && (dnow <= hi_c);
      op.luma_addr   = LumaAw'(32'(row) * FrameWidth + 32'(col));
      op.chroma_addr = ChromaAw'(32'(row >> 1) * ChromaW + 32'(col >> 1));
      op.luma = in_data[42:35];
      op.cb   = in_data[50:43];
      op.cr   = in_data[58:51];
   end

   assign in_ready = (cnt_ff != (QAw+1)'(QDepth));
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;
   assign q_valid = (cnt_ff != '0);
   assign q_op = mem_ff[rp_ff];
   assign wp_in = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in = pop ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in = cnt_ff + (QAw+1)'(push) - (QAw+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TolReset;
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         tol_ff <= tol_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= op;
   end
endmodule

// ----- src/dgcba_back.sv -----
module dgcba_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  dgcba_pkg::op_type q_op,
   output logic              out_valid,
   input  logic              out_ready,
   output dgcba_pkg::rsp_type out_rsp
);
   import dgcba_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [ChromaAw:0] clr_ff, clr_in;
   logic [LumaAw-1:0] lclr_ff, lclr_in;
   rsp_type rsp_ff, rsp_in;
   logic [LumaMemW-1:0]   lrd, lwd;
   logic [ChromaMemW-1:0] crd, cwd;
   logic lwe, cwe;
   logic [LumaAw-1:0]   lwa;
   logic [ChromaAw-1:0] cwa;
   logic [LsumW-1:0] lsum;
   logic [LcntW-1:0] lcnt;
   logic [CsumW-1:0] cbsum, crsum;
   logic [CcntW-1:0] ccnt;
   // three shared restoring dividers, one quotient bit per cycle
   logic [DivW-1:0] rem_ff [3], rem_in [3];
   logic [DivW-1:0] num_ff [3], num_in [3];
   logic [DivW-1:0] den_ff [3];
   logic [4:0] bit_ff, bit_in;
   logic [DivW:0] trial [3];
   logic luma_hit, chroma_hit, lclr_done;

   // read address comes from the held op, so data is ready in ST_EXEC
   dgcba_ram #(.Width(LumaMemW), .Depth(LumaCells)) u_luma (
      .clock, .wr_en(lwe), .wr_addr(lwa), .wr_data(lwd),
      .rd_addr(op_ff.luma_addr), .rd_data(lrd));
   dgcba_ram #(.Width(ChromaMemW), .Depth(ChromaCells)) u_chroma (
      .clock, .wr_en(cwe), .wr_addr(cwa), .wr_data(cwd),
      .rd_addr(op_ff.chroma_addr), .rd_data(crd));

   assign {lsum, lcnt} = lrd;
   assign {cbsum, crsum, ccnt} = crd;
   assign luma_hit   = (32'(lcnt) < MaxLumaCount);
   assign chroma_hit = (32'(ccnt) < MaxChromaCount);
   assign lclr_done  = (32'(lclr_ff) == LumaCells - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (lclr_done && 32'(clr_ff) >= ChromaCells - 1) state_in = ST_IDLE;
         ST_IDLE:  if (q_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  state_in = (op_ff.kind == KIND_READOUT && op_ff.in_frame) ? ST_DIV : ST_OUT;
         ST_DIV:   if (bit_ff == '0) state_in = ST_OUT;
         ST_OUT:   if (out_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_ready = (state_ff == ST_IDLE);
      out_valid = (state_ff == ST_OUT);
      out_rsp = rsp_ff;
      lwe = 1'b0; cwe = 1'b0;
      lwa = op_ff.luma_addr; cwa = op_ff.chroma_addr;
      lwd = '0; cwd = '0;
      rsp_in = rsp_ff;
      clr_in = clr_ff; lclr_in = lclr_ff;
      bit_in = bit_ff;
      for (int i = 0; i < 3; i++) begin
         trial[i]  = {rem_ff[i], num_ff[i][DivW-1]} - {1'b0, den_ff[i]};
         rem_in[i] = rem_ff[i];
         num_in[i] = num_ff[i];
      end
      unique case (state_ff)
         ST_CLEAR: begin
            lwe = 1'b1; lwa = lclr_ff;
            cwe = (32'(clr_ff) < ChromaCells); cwa = clr_ff[ChromaAw-1:0];
            if (!lclr_done) lclr_in = lclr_ff + 1'b1;
            if (32'(clr_ff) < ChromaCells) clr_in = clr_ff + 1'b1;
         end
         ST_EXEC: begin
            rsp_in = '0;
            bit_in = 5'(DivW);
            if (op_ff.in_frame && op_ff.kind == KIND_SAMPLE && op_ff.in_band) begin
               lwe = luma_hit;
               lwd = {lsum + LsumW'(op_ff.luma), lcnt + 1'b1};
               rsp_in.accepted = luma_hit;
               cwe = chroma_hit;
               cwd = {cbsum + CsumW'(op_ff.cb), crsum + CsumW'(op_ff.cr), ccnt + 1'b1};
            end
            num_in[0] = DivW'(lsum); num_in[1] = cbsum; num_in[2] = crsum;
            for (int i = 0; i < 3; i++) rem_in[i] = '0;
         end
         ST_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (!trial[i][DivW]) rem_in[i] = trial[i][DivW-1:0];
               else rem_in[i] = {rem_ff[i][DivW-2:0], num_ff[i][DivW-1]};
               num_in[i] = {num_ff[i][DivW-2:0], !trial[i][DivW]};
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd1) begin
               rsp_in.luma_valid   = (den_ff[0] != '0);
               rsp_in.chroma_valid = (den_ff[1] != '0);
               rsp_in.luma_mean = (den_ff[0] != '0) ? num_in[0][7:0] : 8'd0;
               rsp_in.cb_mean   = (den_ff[1] != '0) ? num_in[1][7:0] : 8'd0;
               rsp_in.cr_mean   = (den_ff[1] != '0) ? num_in[2][7:0] : 8'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         lclr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lclr_ff  <= lclr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ready && q_valid) op_ff <= q_op;
      if (state_ff == ST_EXEC) begin
         den_ff[0] <= DivW'(lcnt);
         den_ff[1] <= DivW'(ccnt);
         den_ff[2] <= DivW'(ccnt);
      end
      rsp_ff <= rsp_in;
      bit_ff <= bit_in;
      for (int i = 0; i < 3; i++) begin
         rem_ff[i] <= rem_in[i];
         num_ff[i] <= num_in[i];
      end
   end
endmodule

// ----- src/depth_gated_color_background_average_unit.sv -----
// Each beat passes ST_IDLE, ST_READ, ST_EXEC and ST_OUT; an in-frame readout adds the ST_DIV divide.
// The back end takes a new beat only after ST_OUT hands off the last response; the front queue holds 4 beats.
// The back end's memory read-modify-write and the shared bit-serial dividers set the rate.
// Reset is synchronous, active high; a clearing pass then zeroes
// the sum/count memories; meanwhile only the 4-beat front queue takes req beats.
module depth_gated_color_background_average_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind
   input  logic        req_tuser,
   // row, col, depth_now, depth_bg, luma, cb_sample, cr_sample (from bit 0)
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted, luma_mean, luma_valid, cb_mean, cr_mean, chroma_valid (from bit 0)
   output logic [31:0] rsp_tdata
);
   import dgcba_pkg::*;

   logic    q_valid, q_ready;
   op_type  q_op;
   rsp_type rsp;

   dgcba_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_kind(req_tuser),
      .in_data(req_tdata[58:0]),
      .q_valid, .q_ready, .q_op);

   dgcba_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_op,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp));

   assign rsp_tdata = {5'd0, rsp.chroma_valid, rsp.cr_mean, rsp.cb_mean,
                       rsp.luma_valid, rsp.luma_mean, rsp.accepted};

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && (rsp_tdata[9] || rsp_tdata[26])))
      else $error("sample beat reports readout fields");
   a_q_sync: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> !q_ready)
      else $error("back end took two items back to back");
   a_mean_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[9]) |-> rsp_tdata[8:1] == 8'd0)
      else $error("luma mean without valid");
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import dgcba_pkg::*;

   // Running model of the background store: per-pixel luma and per-block chroma
   // accumulators, kept sparse since only a few cells are ever touched.
   class bg_average_board;
      logic [7:0]  tolerance;
      int unsigned luma_sum[int];
      int unsigned luma_cnt[int];
      int unsigned cb_sum[int];
      int unsigned cr_sum[int];
      int unsigned chroma_cnt[int];
      rsp_type     pending[$];
      int          mismatches;
      int          samples_seen;
      int          readouts_seen;
      int          hits;

      function new();
         tolerance = TolReset;
         mismatches = 0;
         samples_seen = 0;
         readouts_seen = 0;
         hits = 0;
      endfunction

      function automatic int unsigned get(ref int unsigned a[int], input int key);
         return a.exists(key) ? a[key] : 0;
      endfunction

      // Works out the response for one accepted request beat.
      function void note_request(kind_type kind, logic [63:0] d);
         logic [8:0]  row;
         logic [9:0]  col;
         logic [7:0]  dnow, dbg, y, u, v;
         int          lo, hi, li, ci;
         int unsigned lc, cc;
         rsp_type     r;
         row  = d[8:0];
         col  = d[18:9];
         dnow = d[26:19];
         dbg  = d[34:27];
         y    = d[42:35];
         u    = d[50:43];
         v    = d[58:51];
         r = '0;
         if (row < FrameHeight && col < FrameWidth) begin
            li = row * FrameWidth + col;
            ci = (row >> 1) * ChromaW + (col >> 1);
            lc = get(luma_cnt, li);
            cc = get(chroma_cnt, ci);
            if (kind == KIND_SAMPLE) begin
               samples_seen++;
               lo = (dbg >= tolerance) ? dbg - tolerance : 0;
               hi = dbg + tolerance;
               if (hi > DepthMax) hi = DepthMax;
               if (dnow >= lo && dnow <= hi) begin
                  if (lc < MaxLumaCount) begin
                     luma_sum[li] = get(luma_sum, li) + y;
                     luma_cnt[li] = lc + 1;
                     r.accepted = 1'b1;
                     hits++;
                  end
                  if (cc < MaxChromaCount) begin
                     cb_sum[ci] = get(cb_sum, ci) + u;
                     cr_sum[ci] = get(cr_sum, ci) + v;
                     chroma_cnt[ci] = cc + 1;
                  end
               end
            end else begin
               readouts_seen++;
               if (lc != 0) begin
                  r.luma_mean  = 8'(get(luma_sum, li) / lc);
                  r.luma_valid = 1'b1;
               end
               if (cc != 0) begin
                  r.cb_mean      = 8'(get(cb_sum, ci) / cc);
                  r.cr_mean      = 8'(get(cr_sum, ci) / cc);
                  r.chroma_valid = 1'b1;
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [31:0] d);
         rsp_type e, a;
         a.accepted     = d[0];
         a.luma_mean    = d[8:1];
         a.luma_valid   = d[9];
         a.cb_mean      = d[17:10];
         a.cr_mean      = d[25:18];
         a.chroma_valid = d[26];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response beat with nothing pending: %h", d);
            return;
         end
         e = pending.pop_front();
         if (a.accepted !== e.accepted || a.luma_mean !== e.luma_mean ||
             a.luma_valid !== e.luma_valid || a.cb_mean !== e.cb_mean ||
             a.cr_mean !== e.cr_mean || a.chroma_valid !== e.chroma_valid) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: rsp mismatch exp acc=%0d y=%0d yv=%0d cb=%0d cr=%0d cv=%0d",
                        e.accepted, e.luma_mean, e.luma_valid, e.cb_mean, e.cr_mean,
                        e.chroma_valid);
               $display("                    got acc=%0d y=%0d yv=%0d cb=%0d cr=%0d cv=%0d",
                        a.accepted, a.luma_mean, a.luma_valid, a.cb_mean, a.cr_mean,
                        a.chroma_valid);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   bg_average_board board = new();
   bit          quiet = 1'b0;     // no idling on either side
   bit          hold_rsp = 1'b0;  // request a long receiver stall
   int          idle_cycles = 0;
   // the limit must exceed the clearing pass after reset
   localparam int WatchLimit = 2000000;

   always #6 clock = ~clock;

   depth_gated_color_background_average_unit DUT (.*);

   always @(posedge clock) begin
      if (req_tvalid && req_tready) board.note_request(kind_type'(req_tuser), req_tdata);
      if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      if (csr_valid && csr_ready) board.tolerance = csr_data;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WatchLimit) begin
         $display("ERROR: no progress for %0d cycles", WatchLimit);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stall per beat, or one long hold when asked.
   initial begin
      int w;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         w = quiet ? 0 : $urandom_range(0, 10);
         if (w > 0) begin
            rsp_tready = 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   function automatic logic [63:0] pack_req(int row, int col, int dn, int db,
                                            int y, int u, int v);
      logic [63:0] d;
      d = '0;
      d[8:0]   = row[8:0];
      d[18:9]  = col[9:0];
      d[26:19] = dn[7:0];
      d[34:27] = db[7:0];
      d[42:35] = y[7:0];
      d[50:43] = u[7:0];
      d[58:51] = v[7:0];
      return d;
   endfunction

   // Called at a falling edge; returns at a falling edge after the beat is taken.
   task automatic send_beat(kind_type k, logic [63:0] d);
      int w;
      w = quiet ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
         req_tvalid = 1'b0;
         repeat (w) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = k;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [7:0] t);
      csr_valid = 1'b1;
      csr_data = t;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sample whose depth mostly sits near the band edge for the current tolerance.
   task automatic send_sample(int row, int col, int y, int u, int v);
      int db, dn, off;
      db = $urandom_range(0, 255);
      off = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                      : board.tolerance + $urandom_range(0, 2) - 1;
      dn = $urandom_range(0, 1) ? db + off : db - off;
      if ($urandom_range(0, 4) == 0) dn = $urandom_range(0, 255);
      if (dn < 0) dn = 0;
      if (dn > 255) dn = 255;
      send_beat(KIND_SAMPLE, pack_req(row, col, dn, db, y, u, v));
   endtask

   task automatic random_phase(int n);
      int row, col, k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 7);
         if (k == 0) begin
            row = $urandom_range(0, 511);
            col = $urandom_range(0, 1023);
         end else begin
            // small pool of hot spots near the frame corners
            row = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(508, 511);
            col = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(1020, 1023);
         end
         if ($urandom_range(0, 3) == 0)
            send_beat(KIND_READOUT, pack_req(row, col, $urandom_range(0, 255),
                                             $urandom_range(0, 255), $urandom_range(0, 255),
                                             $urandom_range(0, 255), $urandom_range(0, 255)));
         else
            send_sample(row, col, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // readout of a cell never written, then depth band edges at reset tolerance
      send_beat(KIND_READOUT, pack_req(0, 0, 0, 0, 0, 0, 0));
      send_beat(KIND_SAMPLE, pack_req(0, 0, 0, 0, 255, 255, 255));
      send_beat(KIND_SAMPLE, pack_req(511, 1023, 255, 255, 255, 0, 255));
      send_beat(KIND_SAMPLE, pack_req(511, 1023, 255, 247, 0, 255, 0));
      send_beat(KIND_SAMPLE, pack_req(511, 1023, 255, 246, 7, 7, 7));
      send_beat(KIND_SAMPLE, pack_req(5, 6, 108, 100, 10, 20, 30));
      send_beat(KIND_SAMPLE, pack_req(5, 6, 109, 100, 40, 50, 60));
      send_beat(KIND_SAMPLE, pack_req(5, 7, 92, 100, 90, 80, 70));
      send_beat(KIND_SAMPLE, pack_req(4, 6, 91, 100, 90, 80, 70));
      send_beat(KIND_READOUT, pack_req(0, 0, 255, 255, 255, 255, 255));
      send_beat(KIND_READOUT, pack_req(511, 1023, 0, 0, 0, 0, 0));
      send_beat(KIND_READOUT, pack_req(5, 6, 0, 0, 0, 0, 0));
      send_beat(KIND_READOUT, pack_req(4, 7, 0, 0, 0, 0, 0));
      send_beat(KIND_READOUT, pack_req(4, 6, 0, 0, 0, 0, 0));
      send_beat(KIND_READOUT, pack_req(510, 1022, 0, 0, 0, 0, 0));

      // Fill the queue against a stalled receiver.
      hold_rsp = 1'b1;
      random_phase(20);
      drain();

      write_tolerance(8'd0);
      random_phase(80);
      drain();
      write_tolerance(8'd255);
      random_phase(80);
      drain();
      write_tolerance(8'($urandom_range(1, 40)));
      quiet = 1'b1;
      random_phase(50);
      quiet = 1'b0;
      random_phase(50);
      drain();

      // Saturate one luma cell; its chroma block keeps counting.
      write_tolerance(8'd255);
      quiet = 1'b1;
      for (int i = 0; i < 1030; i++)
         send_beat(KIND_SAMPLE, pack_req(100, 200, $urandom_range(0, 255),
                                         $urandom_range(0, 255), $urandom_range(200, 255),
                                         255, $urandom_range(0, 255)));
      quiet = 1'b0;
      for (int i = 0; i < 4; i++)
         send_beat(KIND_READOUT, pack_req(100 + (i & 1), 200 + (i >> 1), 0, 0, 0, 0, 0));
      drain();

      write_tolerance(8'd8);
      random_phase(120);
      drain();

      $display("Covered %0d sample beats (%0d summed) and %0d readouts,",
               board.samples_seen, board.hits, board.readouts_seen);
      $display("tolerances 0, 8, 255 and random, a saturated luma cell and a long output stall.");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else begin
         $display("ERROR: %0d mismatches, %0d responses missing",
                  board.mismatches, board.pending.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/dgcba_pkg.sv
src/dgcba_ram.sv
src/dgcba_front.sv
src/dgcba_back.sv
src/depth_gated_color_background_average_unit.sv
test/testbench.sv
